>>> src/lookup2_key_hash_case_fold_core_assert.svh
// Assertion macros shared by the lookup2 key hash checker.
// Clock and reset are taken to be named clk and rst where a macro is used.
`ifndef LOOKUP2_KEY_HASH_CASE_FOLD_CORE_ASSERT_SVH
`define LOOKUP2_KEY_HASH_CASE_FOLD_CORE_ASSERT_SVH

// next-cycle check, not masked by reset
`define L2H_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// next-cycle check, masked while reset is high
`define L2H_ASSERT_RUN(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/l2h_pkg.sv
// Shared types and constants for the lookup2 key hash core.
// No dependencies; used by all core modules.
package l2h_pkg;

  localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
  localparam logic [3:0]  BLOCK_LAST  = 4'd11;
  localparam int          QUEUE_DEPTH = 2;

  // one unit of work for the mixing back end
  typedef struct packed {
    logic [31:0] a_add;
    logic [31:0] b_add;
    logic [31:0] c_add;
    logic [31:0] len;    // key length, added after a block mix that also ends the key
    logic [31:0] seed;   // start value of word c, used when first is set
    logic        first;  // first job of a key: start from the initial words
    logic        blk;    // full 12-byte block: mix with c_add
    logic        fin;    // key ends with this job
  } job_t;

endpackage

>>> src/l2h_ifs.sv
// Channel interfaces of the lookup2 key hash core: key bytes, hashes, seed writes.
// Valid/ready handshake; a word moves when both are high at a rising edge.
interface l2h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       byte_present;
  logic       last;
  logic       mode;

  modport source (output valid, key_byte, byte_present, last, mode, input ready);
  modport sink   (input valid, key_byte, byte_present, last, mode, output ready);
endinterface

interface l2h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface l2h_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

>>> src/l2h_front.sv
// Front end: takes key bytes, folds case, packs 12-byte blocks into mix jobs.
// Depends on l2h_pkg and l2h_in_if.
module l2h_front (
  input  logic          clk,
  input  logic          rst,
  l2h_in_if.sink        keys,
  input  logic [31:0]   seed,
  output l2h_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);

  logic [3:0]  pos;
  logic [31:0] acc_a;
  logic [31:0] acc_b;
  logic [23:0] tail;
  logic [31:0] len;
  logic        key_open;
  logic        sent;
  logic [31:0] seed_key;

  logic [7:0]  folded;
  logic        accept;
  logic        blk;
  logic [4:0]  sh;
  logic [31:0] a_next;
  logic [31:0] b_next;
  logic [23:0] tail_next;
  logic [31:0] len_next;

  assign keys.ready = job_ready;
  assign accept     = keys.valid && keys.ready;
  assign sh         = {pos[1:0], 3'b000};

  always_comb begin
    folded = keys.key_byte;
    if (!keys.mode && keys.key_byte >= 8'h61 && keys.key_byte <= 8'h7a) begin
      folded = keys.key_byte - 8'h20;
    end
  end

  always_comb begin
    a_next    = acc_a;
    b_next    = acc_b;
    tail_next = tail;
    if (keys.byte_present) begin
      if (pos[3:2] == 2'b00) begin
        a_next = acc_a | ({24'h0, folded} << sh);
      end
      if (pos[3:2] == 2'b01) begin
        b_next = acc_b | ({24'h0, folded} << sh);
      end
      if (pos[3:2] == 2'b10 && pos[1:0] != 2'b11) begin
        tail_next = tail | ({16'h0, folded} << sh);
      end
    end
  end

  assign blk      = keys.byte_present && (pos == l2h_pkg::BLOCK_LAST);
  assign len_next = len + {31'h0, keys.byte_present};

  always_comb begin
    job.a_add = a_next;
    job.b_add = b_next;
    job.c_add = blk ? {folded, tail} : len_next + {tail_next, 8'h00};
    job.len   = len_next;
    job.seed  = key_open ? seed_key : seed;
    job.first = !sent;
    job.blk   = blk;
    job.fin   = keys.last;
  end

  assign job_valid = accept && (blk || keys.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      acc_a    <= '0;
      acc_b    <= '0;
      tail     <= '0;
      len      <= '0;
      key_open <= 1'b0;
      sent     <= 1'b0;
    end else if (accept) begin
      if (keys.last) begin
        pos      <= '0;
        acc_a    <= '0;
        acc_b    <= '0;
        tail     <= '0;
        len      <= '0;
        key_open <= 1'b0;
        sent     <= 1'b0;
      end else begin
        key_open <= 1'b1;
        len      <= len_next;
        if (blk) begin
          pos   <= '0;
          acc_a <= '0;
          acc_b <= '0;
          tail  <= '0;
          sent  <= 1'b1;
        end else if (keys.byte_present) begin
          pos   <= pos + 4'd1;
          acc_a <= a_next;
          acc_b <= b_next;
          tail  <= tail_next;
        end
      end
    end
  end

  // seed is sampled by the first word of each key
  always_ff @(posedge clk) begin
    if (accept && !key_open) begin
      seed_key <= seed;
    end
  end

endmodule

>>> src/l2h_queue.sv
// Job queue between front and back end of the lookup2 key hash core.
// Depends on l2h_pkg.
module l2h_queue #(
  parameter int DEPTH = l2h_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  l2h_pkg::job_t wr_job,
  input  logic          wr_valid,
  output logic          wr_ready,
  output l2h_pkg::job_t rd_job,
  output logic          rd_valid,
  input  logic          rd_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  l2h_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_FULL);
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/l2h_back.sv
// Back end: iterative lookup2 mixer, one of nine rounds a cycle, and hash output register.
// Depends on l2h_pkg and l2h_out_if.
module l2h_back (
  input  logic          clk,
  input  logic          rst,
  input  l2h_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  l2h_out_if.source     hashes
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t      state;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] z;
  logic [3:0]  step;
  logic        blk;
  logic        fin;
  logic [31:0] len;
  logic        hash_valid;
  logic [31:0] hash;

  logic [31:0] x_next;
  logic [31:0] y_next;
  logic [31:0] z_next;
  logic [31:0] base_a;
  logic [31:0] base_b;
  logic [31:0] base_c;
  logic        out_free;

  assign job_ready         = (state == ST_IDLE);
  assign out_free          = !hash_valid || hashes.ready;
  assign hashes.valid      = hash_valid;
  assign hashes.hash_value = hash;

  assign base_a = job.first ? l2h_pkg::GOLDEN_WORD : x;
  assign base_b = job.first ? l2h_pkg::GOLDEN_WORD : y;
  assign base_c = job.first ? job.seed : z;

  // one round of the mix: update one word from the other two
  always_comb begin
    x_next = x;
    y_next = y;
    z_next = z;
    unique case (step)
      4'd0:    x_next = (x - y - z) ^ (z >> 13);
      4'd1:    y_next = (y - z - x) ^ (x << 8);
      4'd2:    z_next = (z - x - y) ^ (y >> 13);
      4'd3:    x_next = (x - y - z) ^ (z >> 12);
      4'd4:    y_next = (y - z - x) ^ (x << 16);
      4'd5:    z_next = (z - x - y) ^ (y >> 5);
      4'd6:    x_next = (x - y - z) ^ (z >> 3);
      4'd7:    y_next = (y - z - x) ^ (x << 10);
      4'd8:    z_next = (z - x - y) ^ (y >> 15);
      default: z_next = z;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      blk   <= 1'b0;
      fin   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            x     <= base_a + job.a_add;
            y     <= base_b + job.b_add;
            z     <= base_c + job.c_add;
            len   <= job.len;
            blk   <= job.blk;
            fin   <= job.fin;
            step  <= '0;
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          if (step == 4'd8) begin
            if (blk && fin) begin
              blk   <= 1'b0;
              state <= ST_ADD;
            end else if (fin) begin
              state <= ST_OUT;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_ADD: begin
          // key ended on a full block: length goes into a further mix
          z     <= z + len;
          step  <= '0;
          state <= ST_MIX;
        end
        ST_OUT: begin
          if (out_free) begin
            hash  <= z;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      hash_valid <= 1'b1;
    end else if (hashes.ready) begin
      hash_valid <= 1'b0;
    end
  end

endmodule

>>> src/lookup2_key_hash_case_fold_core.sv
// Streaming lookup2 key hash core with optional a-z case folding, top level.
// Depends on l2h_pkg, l2h_ifs, l2h_front, l2h_queue, l2h_back.
//
// Key bytes enter one word per cycle on keys while keys.ready is high; the hash of
// a key leaves on hashes after the word marked last. The front end packs bytes into
// 12-byte blocks and hands mix jobs through a QUEUE_DEPTH-entry queue to a single
// mixing unit that runs one of the nine mix rounds per cycle. A full block costs the
// back end one load and nine rounds, and the end of a key a load, nine rounds and an
// output load; a key that ends on a full block adds the length to word c and runs a
// further nine rounds before the output load. The back end takes no new job until it
// is through with the last, so the input stalls once the queue fills. The hash follows
// the last word through the queue, the load, the rounds and the output load.
// The seed register applies from the next key whose first word arrives after the write.
module lookup2_key_hash_case_fold_core #(
  parameter int QUEUE_DEPTH = l2h_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  l2h_in_if.sink     keys,
  l2h_out_if.source  hashes,
  l2h_cfg_if.sink    cfg
);

  logic [31:0]   seed;
  l2h_pkg::job_t front_job;
  logic          front_valid;
  logic          front_ready;
  l2h_pkg::job_t back_job;
  logic          back_valid;
  logic          back_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg.valid && cfg.ready) begin
      seed <= cfg.seed;
    end
  end

  l2h_front u_front (
    .clk       (clk),
    .rst       (rst),
    .keys      (keys),
    .seed      (seed),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  l2h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (front_job),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_job   (back_job),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  l2h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .hashes    (hashes)
  );

endmodule

>>> src/l2h_checker.sv
// Port-level checker for the lookup2 key hash core, bound to the top level.
// Depends on l2h_ifs and the assertion macro header.
`include "lookup2_key_hash_case_fold_core_assert.svh"

module l2h_checker (
  input logic       clk,
  input logic       rst,
  l2h_in_if.sink    keys,
  l2h_out_if.source hashes
);

  `L2H_ASSERT_RUN(a_hash_hold, hashes.valid && !hashes.ready, hashes.valid && $stable(hashes.hash_value), "hash word changed or dropped while stalled")
  `L2H_ASSERT_NEXT(a_rst_no_hash, rst, !hashes.valid, "hash word valid right after reset")
  `L2H_ASSERT_NEXT(a_rst_ready, rst, keys.ready, "key input not ready after reset")

endmodule

bind lookup2_key_hash_case_fold_core l2h_checker u_l2h_checker (
  .clk    (clk),
  .rst    (rst),
  .keys   (keys),
  .hashes (hashes)
);
